FILE: src/bcpc_pkg.sv
// ----------------------------------------------------------------------------
// BLDC commutation package
// Shared types, constants and lookup functions for the hall commutation and
// position control block.
// ----------------------------------------------------------------------------
package bcpc_pkg;

  // Default position counter width and the minimum width of the work registers.
  localparam int POSITION_BITS_DEF = 32;
  localparam int WORK_BITS_MIN     = 52;

  // Stream and configuration port widths.
  localparam int IN_DATA_BITS   = 8;
  localparam int OUT_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  // Field widths.
  localparam int HALL_BITS      = 3;
  localparam int ORIGIN_BITS    = 3;
  localparam int TARGET_BITS    = 32;
  localparam int SPEED_BITS     = 13;
  localparam int PERIOD_BITS    = 16;
  localparam int DRIVE_BITS     = 6;
  localparam int POS_OUT_BITS   = 32;
  localparam int DIR_BITS       = 2;
  localparam int LEAD_BITS      = 3;
  localparam int OUT_PAD_BITS   = OUT_DATA_BITS - DRIVE_BITS - POS_OUT_BITS - DIR_BITS
                                  - PERIOD_BITS - LEAD_BITS;

  // Saturation limits of the control law.
  localparam int DELTA_LIM_EXP = 40;
  localparam int POS_LIM_EXP   = 41;
  localparam int IV_LIMIT      = 880;

  // Reset values.
  localparam logic [SPEED_BITS-1:0]  SPEED_LIMIT_RESET = 13'd600;
  localparam logic [PERIOD_BITS-1:0] PWM_PERIOD_RESET  = 16'd2272;

  // Commutation lead values.
  localparam logic signed [LEAD_BITS-1:0] LEAD_FWD  = 3'sd2;
  localparam logic signed [LEAD_BITS-1:0] LEAD_REV  = -3'sd2;
  localparam logic signed [LEAD_BITS-1:0] LEAD_NONE = 3'sd0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ROTOR_ORIGIN  = 2'd0,
    REG_GOAL_POSITION = 2'd1,
    REG_SPEED_LIMIT   = 2'd2,
    REG_PWM_PERIOD    = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_HALL = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_HALL,
    T_DELTA,
    T_ERR,
    T_VEL,
    T_SMS,
    T_VERR,
    T_IV,
    T_YS1,
    T_YS2,
    T_YR1,
    T_YR2,
    T_YR3,
    T_YR4,
    T_YR5,
    T_CMP,
    T_ABS,
    T_LIM,
    S_OUT
  } state_t;

  // Control of the shared adder: subtract b, and force operand a to zero.
  typedef struct packed {
    logic sub;
    logic zero_a;
  } alu_ctl_t;

  // Hall code to rotor state. The two impossible codes map to state 7.
  function automatic logic [2:0] rotor_state(input logic [HALL_BITS-1:0] hall);
    logic [2:0] rs;
    case (hall)
      3'd0:    rs = 3'd7;
      3'd1:    rs = 3'd5;
      3'd2:    rs = 3'd3;
      3'd3:    rs = 3'd4;
      3'd4:    rs = 3'd1;
      3'd5:    rs = 3'd0;
      3'd6:    rs = 3'd2;
      default: rs = 3'd7;
    endcase
    return rs;
  endfunction

  // Drive state to phase switch pattern. States 6 and 7 switch everything off.
  function automatic logic [DRIVE_BITS-1:0] drive_byte(input logic [2:0] idx);
    logic [DRIVE_BITS-1:0] pat;
    case (idx)
      3'd0:    pat = 6'h12;
      3'd1:    pat = 6'h18;
      3'd2:    pat = 6'h09;
      3'd3:    pat = 6'h21;
      3'd4:    pat = 6'h24;
      3'd5:    pat = 6'h06;
      default: pat = 6'h00;
    endcase
    return pat;
  endfunction

  // Truncating remainder by six of a sum in the range -3..15, low three bits.
  // A negative sum is its own remainder and keeps its two's complement bits.
  function automatic logic [2:0] drive_index(input logic signed [5:0] s);
    logic signed [5:0] t;
    t = s;
    if (s >= 6'sd12) begin
      t = s - 6'sd12;
    end else if (s >= 6'sd6) begin
      t = s - 6'sd6;
    end
    return t[2:0];
  endfunction

endpackage

FILE: src/bldc_commutation_position_control.sv
// ----------------------------------------------------------------------------
// BLDC hall commutation with position control
// Steps a rotor position count from hall samples, produces the phase drive
// pattern, and runs a position and speed controller on each control tick.
// ----------------------------------------------------------------------------
// Each request on the input stream is either a hall sample (tuser low, hall
// bits in tdata) or a 100 ms control tick (tuser high), and each one produces
// exactly one result carrying the drive pattern, the position count, the
// spin direction, the pulse width and the phase lead. The block handles one
// request at a time and drops tready until the result has been placed in the
// output register. All arithmetic runs through a single shared add/subtract
// unit stepped by a small sequencer, with products by the small controller
// gains built from shifted adds. A hall sample passes through the hall step and
// the output state before the block is ready again; a control tick runs its
// sixteen adder steps before the output state. A result that is not
// taken holds the block in its output state once a second result is ready.
// Configuration writes are always accepted and must only be issued while the
// block is idle. A new phase lead computed on a tick is applied from the next
// hall sample on.
// ----------------------------------------------------------------------------
module bldc_commutation_position_control #(
  parameter int POSITION_BITS = bcpc_pkg::POSITION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input stream. tdata: [2:0] hall_bits, [7:3] zero. tuser: mode.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [bcpc_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  input  logic                                  s_axis_tuser,
  // Result stream. tdata: [5:0] drive_pattern, [37:6] rotor_position,
  // [39:38] spin_direction, [55:40] pulse_width, [58:56] phase_lead,
  // [63:59] zero.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [bcpc_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bcpc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bcpc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import bcpc_pkg::*;

  // The work width holds every intermediate of the control law (below 2^50)
  // as well as the full position count.
  localparam int AW = (POSITION_BITS > WORK_BITS_MIN) ? POSITION_BITS : WORK_BITS_MIN;
  localparam int XW = (POSITION_BITS > POS_OUT_BITS) ? POSITION_BITS : POS_OUT_BITS;

  localparam logic signed [AW-1:0] DELTA_LIM =
    {{(AW-DELTA_LIM_EXP-1){1'b0}}, 1'b1, {DELTA_LIM_EXP{1'b0}}};
  localparam logic signed [AW-1:0] POS_LIM =
    {{(AW-POS_LIM_EXP-1){1'b0}}, 1'b1, {POS_LIM_EXP{1'b0}}};
  localparam logic signed [AW-1:0] IV_LIM = AW'(IV_LIMIT);

  // Symmetric saturation against a positive constant limit.
  function automatic logic signed [AW-1:0] sat(input logic signed [AW-1:0] v,
                                               input logic signed [AW-1:0] lim);
    logic signed [AW-1:0] r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [ORIGIN_BITS-1:0]          rotor_origin;
  logic signed [TARGET_BITS-1:0]   goal_position;
  logic [SPEED_BITS-1:0]           speed_limit;
  logic [PERIOD_BITS-1:0]          pwm_period;

  // Architectural state.
  logic [HALL_BITS-1:0]            in_hall;
  logic [2:0]                      last_rotor_state;
  logic [POSITION_BITS-1:0]        position_count;
  logic [POSITION_BITS-1:0]        position_at_tick;
  logic signed [DIR_BITS-1:0]      direction_reg;
  logic signed [LEAD_BITS-1:0]     lead_reg;
  logic [DRIVE_BITS-1:0]           drive_reg;
  logic [PERIOD_BITS-1:0]          pulse_reg;

  // Controller work registers: clamped position change, clamped position
  // error, velocity, speed error, y_s and a general accumulator.
  logic signed [AW-1:0]            dl;
  logic signed [AW-1:0]            er;
  logic signed [AW-1:0]            vel;
  logic signed [AW-1:0]            verr;
  logic signed [AW-1:0]            ys;
  logic signed [AW-1:0]            acc;

  // Output register.
  logic                            out_valid;
  logic [OUT_DATA_BITS-1:0]        out_data;
  logic                            out_free;

  // Shared adder.
  alu_ctl_t                        alu_ctl;
  logic signed [AW-1:0]            alu_a;
  logic signed [AW-1:0]            alu_b;
  logic signed [AW-1:0]            alu_y;

  // Hall sample decode.
  logic [2:0]                      rs;
  logic signed [3:0]               hall_diff;
  logic signed [DIR_BITS-1:0]      hall_sgn;
  logic                            hall_dir_upd;
  logic signed [5:0]               drive_sum;

  // Position views.
  logic signed [AW-1:0]            pc_ext;
  logic signed [AW-1:0]            pat_ext;
  logic signed [XW-1:0]            pc_x;
  logic signed [AW-1:0]            power_sel;
  logic                            ys_lt_yr;
  logic                            ys_gt_yr;

  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign pc_ext  = AW'($signed(position_count));
  assign pat_ext = AW'($signed(position_at_tick));
  assign pc_x    = XW'($signed(position_count));

  // The rotor state difference runs from -7 to 7; a step under five in
  // magnitude is trusted as a direction indication.
  assign rs           = rotor_state(in_hall);
  assign hall_diff    = $signed({1'b0, rs}) - $signed({1'b0, last_rotor_state});
  assign hall_sgn     = (hall_diff > 4'sd0) ? 2'sd1 :
                        (hall_diff < 4'sd0) ? -2'sd1 : 2'sd0;
  assign hall_dir_upd = (hall_diff < 4'sd5) && (hall_diff > -4'sd5);
  assign drive_sum    = $signed({3'b000, rs}) - $signed({3'b000, rotor_origin})
                        + 6'(lead_reg) + 6'sd6;

  // Power selection: the smaller of y_s and y_r while the rotor moves forward
  // or stands, the larger while it moves backward. The sign of the velocity
  // is the sign of the clamped position change.
  assign ys_lt_yr  = alu_y[AW-1];
  assign ys_gt_yr  = !alu_y[AW-1] && (alu_y != '0);
  assign power_sel = !dl[AW-1] ? (ys_lt_yr ? ys : acc) : (ys_gt_yr ? ys : acc);

  bcpc_alu #(
    .WIDTH (AW)
  ) u_alu (
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y)
  );

  // Operand selection for each step. Products by the gains are formed as
  // shifted sums: 10x = 8x + 2x, 15x = 16x - x, 85e = 64e + 16e + 4e + e,
  // and 150 delta = 15 * velocity.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_ctl = '0;
    case (state)
      S_HALL: begin
        alu_a       = pc_ext;
        alu_b       = AW'(1);
        alu_ctl.sub = hall_diff[3];
      end
      T_DELTA: begin
        alu_a       = pc_ext;
        alu_b       = pat_ext;
        alu_ctl.sub = 1'b1;
      end
      T_ERR: begin
        alu_a       = AW'(goal_position);
        alu_b       = sat(pc_ext, POS_LIM);
        alu_ctl.sub = 1'b1;
      end
      T_VEL: begin
        alu_a = dl <<< 3;
        alu_b = dl <<< 1;
      end
      T_SMS: begin
        alu_ctl.zero_a = 1'b1;
        alu_b          = (er == '0) ? '0 : AW'(speed_limit);
        alu_ctl.sub    = er[AW-1];
      end
      T_VERR: begin
        alu_a       = acc;
        alu_b       = vel;
        alu_ctl.sub = 1'b1;
      end
      T_IV: begin
        alu_a = verr <<< 3;
        alu_b = verr <<< 1;
      end
      T_YS1: begin
        alu_a = verr;
        alu_b = acc;
      end
      T_YS2: begin
        alu_a       = acc <<< 4;
        alu_b       = acc;
        alu_ctl.sub = 1'b1;
      end
      T_YR1: begin
        alu_a = er <<< 6;
        alu_b = er <<< 4;
      end
      T_YR2: begin
        alu_a = acc;
        alu_b = er <<< 2;
      end
      T_YR3: begin
        alu_a = acc;
        alu_b = er;
      end
      T_YR4: begin
        alu_a       = acc;
        alu_b       = vel <<< 4;
        alu_ctl.sub = 1'b1;
      end
      T_YR5: begin
        alu_a = acc;
        alu_b = vel;
      end
      T_CMP: begin
        alu_a       = ys;
        alu_b       = acc;
        alu_ctl.sub = 1'b1;
      end
      T_ABS: begin
        alu_ctl.zero_a = 1'b1;
        alu_b          = acc;
        alu_ctl.sub    = acc[AW-1];
      end
      T_LIM: begin
        alu_a       = acc;
        alu_b       = AW'(pwm_period);
        alu_ctl.sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_ctl = '0;
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and input handshake.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = (mode_t'(s_axis_tuser) == MODE_TICK) ? T_DELTA : S_HALL;
        end
      end
      S_HALL:  state_next = S_OUT;
      T_DELTA: state_next = T_ERR;
      T_ERR:   state_next = T_VEL;
      T_VEL:   state_next = T_SMS;
      T_SMS:   state_next = T_VERR;
      T_VERR:  state_next = T_IV;
      T_IV:    state_next = T_YS1;
      T_YS1:   state_next = T_YS2;
      T_YS2:   state_next = T_YR1;
      T_YR1:   state_next = T_YR2;
      T_YR2:   state_next = T_YR3;
      T_YR3:   state_next = T_YR4;
      T_YR4:   state_next = T_YR5;
      T_YR5:   state_next = T_CMP;
      T_CMP:   state_next = T_ABS;
      T_ABS:   state_next = T_LIM;
      T_LIM:   state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rotor_origin  <= '0;
      goal_position <= '0;
      speed_limit   <= SPEED_LIMIT_RESET;
      pwm_period    <= PWM_PERIOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROTOR_ORIGIN:  rotor_origin  <= cfg_data[ORIGIN_BITS-1:0];
        REG_GOAL_POSITION: goal_position <= $signed(cfg_data[TARGET_BITS-1:0]);
        REG_SPEED_LIMIT:   speed_limit   <= cfg_data[SPEED_BITS-1:0];
        REG_PWM_PERIOD:    pwm_period    <= cfg_data[PERIOD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Architectural state updated by hall samples and control ticks.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_rotor_state <= '0;
      position_count   <= '0;
      position_at_tick <= '0;
      direction_reg    <= '0;
      lead_reg         <= LEAD_FWD;
      drive_reg        <= '0;
      pulse_reg        <= '0;
    end else begin
      case (state)
        S_HALL: begin
          // The count moves one step toward the sign of the state difference.
          if (hall_diff != 4'sd0) begin
            position_count <= alu_y[POSITION_BITS-1:0];
          end
          if (hall_dir_upd) begin
            direction_reg <= hall_sgn;
          end
          last_rotor_state <= rs;
          drive_reg        <= drive_byte(drive_index(drive_sum));
        end
        T_ABS: begin
          if (!acc[AW-1] && (acc != '0)) begin
            lead_reg <= LEAD_FWD;
          end else if (acc[AW-1]) begin
            lead_reg <= LEAD_REV;
          end else begin
            lead_reg <= LEAD_NONE;
          end
        end
        T_LIM: begin
          // A negative difference means the magnitude is below the period.
          pulse_reg        <= alu_y[AW-1] ? acc[PERIOD_BITS-1:0] : pwm_period;
          position_at_tick <= position_count;
        end
        default: begin
        end
      endcase
    end
  end

  // Input capture and controller work registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          in_hall <= s_axis_tdata[HALL_BITS-1:0];
        end
      end
      T_DELTA: dl   <= sat(AW'($signed(alu_y[POSITION_BITS-1:0])), DELTA_LIM);
      T_ERR:   er   <= sat(alu_y, DELTA_LIM);
      T_VEL:   vel  <= alu_y;
      T_SMS:   acc  <= alu_y;
      T_VERR:  verr <= alu_y;
      T_IV:    acc  <= sat(alu_y, IV_LIM);
      T_YS1:   acc  <= alu_y;
      T_YS2:   ys   <= alu_y;
      T_YR1:   acc  <= alu_y;
      T_YR2:   acc  <= alu_y;
      T_YR3:   acc  <= alu_y;
      T_YR4:   acc  <= alu_y;
      T_YR5:   acc  <= alu_y;
      T_CMP:   acc  <= power_sel;
      T_ABS: begin
        if (acc[AW-1]) begin
          acc <= alu_y;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: filled from the current state once the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      out_data <= {{OUT_PAD_BITS{1'b0}}, lead_reg, pulse_reg, direction_reg,
                   pc_x[POS_OUT_BITS-1:0], drive_reg};
    end
  end

endmodule

FILE: src/bcpc_alu.sv
// ----------------------------------------------------------------------------
// BLDC commutation shared adder
// The single add/subtract unit that the control sequencer reuses for each step.
// ----------------------------------------------------------------------------
module bcpc_alu #(
  parameter int WIDTH = bcpc_pkg::WORK_BITS_MIN
) (
  input  bcpc_pkg::alu_ctl_t        ctl,
  input  logic signed [WIDTH-1:0]   a,
  input  logic signed [WIDTH-1:0]   b,
  output logic signed [WIDTH-1:0]   y
);

  logic [WIDTH-1:0] a_op;
  logic [WIDTH-1:0] b_op;

  // Subtraction is the sum with the inverted operand and a carry in.
  assign a_op = ctl.zero_a ? '0 : a;
  assign b_op = ctl.sub ? ~b : b;
  assign y    = a_op + b_op + WIDTH'(ctl.sub);

endmodule

FILE: src/bcpc_checker.sv
// ----------------------------------------------------------------------------
// BLDC commutation port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module bcpc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [bcpc_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    !rst && s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a request is in progress");

  // A stalled result stays offered and unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !rst && m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Lead is -2, 0 or +2, direction is -1, 0 or +1, and the pad bits are zero.
  a_result_codes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[58:56] == 3'b010) || (m_axis_tdata[58:56] == 3'b000)
                       || (m_axis_tdata[58:56] == 3'b110))
                      && (m_axis_tdata[39:38] != 2'b10) && (m_axis_tdata[63:59] == 5'd0))
    else $error("result carries an impossible lead or direction code");

endmodule

bind bldc_commutation_position_control bcpc_checker u_bcpc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
